FILE: rtl/htlp_pkg.sv
// Package for the linear-probe hash table: sizes, action and result codes,
// slot status codes and the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package htlp_pkg;

  localparam int TableSlots = 64;
  localparam int KeyChars   = 8;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int LapW       = $clog2(TableSlots + 1);
  localparam int KeyW       = 8 * KeyChars;
  localparam int LenW       = 4;
  localparam int ValW       = 64;
  localparam int CountW     = 7;
  localparam int StepW      = $clog2(KeyChars + 1);

  localparam logic [2:0] ActSearch = 3'd0;
  localparam logic [2:0] ActUpdate = 3'd1;
  localparam logic [2:0] ActInsert = 3'd2;
  localparam logic [2:0] ActRemove = 3'd3;
  localparam logic [2:0] ActClear  = 3'd4;

  localparam logic [1:0] RcOk       = 2'd0;
  localparam logic [1:0] RcNotFound = 2'd1;
  localparam logic [1:0] RcDup      = 2'd2;
  localparam logic [1:0] RcFull     = 2'd3;

  localparam logic [1:0] StUnused  = 2'd0;
  localparam logic [1:0] StInUse   = 2'd1;
  localparam logic [1:0] StDeleted = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request word
    logic hash_step;  // one multiply-add of the hash
    logic probe_init; // set probe position to home slot
    logic rd;         // read slot at probe position
    logic eval;       // examine the slot read last cycle
    logic wr_ins;     // write the request into the free slot
    logic wr_val;     // write the value into the hit slot
    logic del;        // mark the hit slot deleted
    logic clear_step; // mark the slot at the wipe pointer unused
  } htlp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic hit;        // eval found the key
    logic stop;       // eval found an unused slot or lap ended
    logic have_free;
    logic full;       // live count at or above the limit
    logic clear_done; // the wipe pointer is at the last slot
  } htlp_sts_t;

endpackage

FILE: rtl/htlp_datapath.sv
// Datapath of the hash table: request register, hash unit, probe pointer,
// slot memories, slot status memory with its wipe pointer, and the live
// counter. Uses htlp_pkg.
`timescale 1ns / 1ps

module htlp_datapath
  import htlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  htlp_cmd_t         cmd,
  output htlp_sts_t         sts,
  input  logic [2:0]        action_in,
  input  logic [KeyW-1:0]   key_in,
  input  logic [LenW-1:0]   len_in,
  input  logic [ValW-1:0]   val_in,
  input  logic [CountW-1:0] fill_limit,
  output logic [2:0]        action,
  output logic [ValW-1:0]   hit_value
);

  logic [KeyW-1:0]  key;
  logic [LenW-1:0]  len;
  logic [ValW-1:0]  value;
  logic [31:0]      hash;
  logic [StepW-1:0] step;
  logic [SlotW-1:0] pos;
  logic [LapW-1:0]  lap;
  logic [SlotW-1:0] hit_slot;
  logic [SlotW-1:0] free_slot;
  logic             have_free;
  logic             have_del;
  logic [CountW-1:0] live;
  logic [1:0]       status [TableSlots];
  logic [SlotW-1:0] clr_ptr;

  logic [KeyW-1:0]  mem_key [TableSlots];
  logic [LenW-1:0]  mem_len [TableSlots];
  logic [ValW-1:0]  mem_val [TableSlots];
  logic [KeyW-1:0]  rd_key;
  logic [LenW-1:0]  rd_len;
  logic [1:0]       rd_st;
  logic [SlotW-1:0] rd_pos;

  logic [LenW-1:0]  len_cl;
  logic [KeyW-1:0]  key_mask;
  logic [7:0]       ch;
  logic [SlotW-1:0] wr_addr;

  // Clamp length and zero the unused key bytes.
  always_comb begin
    len_cl = (len_in > LenW'(KeyChars)) ? LenW'(KeyChars) : len_in;
    for (int b = 0; b < KeyChars; b++) begin
      key_mask[8*b +: 8] = (LenW'(b) < len_cl) ? 8'hFF : 8'h00;
    end
    ch = key[8*step[$clog2(KeyChars)-1:0] +: 8];
  end

  // Request register and hash iteration, one character per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= action_in;
      key    <= key_in & key_mask;
      len    <= len_cl;
      value  <= val_in;
      hash   <= '0;
      step   <= '0;
    end else if (cmd.hash_step && !sts.hash_done) begin
      hash <= hash * 32'(step) + 32'(ch);
      step <= step + 1'b1;
    end
  end

  assign sts.hash_done = (LenW'(step) >= len);
  assign sts.full      = (live >= fill_limit);

  // Probe walk state.
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      pos       <= hash[SlotW-1:0];
      lap       <= '0;
      have_free <= 1'b0;
      have_del  <= 1'b0;
    end else begin
      if (cmd.rd) begin
        pos <= pos + 1'b1;
        lap <= lap + 1'b1;
      end
      if (cmd.eval && !have_del && rd_st == StDeleted) begin
        have_del  <= 1'b1;
        have_free <= 1'b1;
        free_slot <= rd_pos;
      end else if (cmd.eval && !have_del && rd_st == StUnused) begin
        have_free <= 1'b1;
        free_slot <= rd_pos;
      end
      if (cmd.eval) begin
        hit_slot <= rd_pos;
      end
    end
  end

  assign sts.hit = (rd_st == StInUse) && (rd_len == len) && (rd_key == key);
  assign sts.stop = (rd_st == StUnused) || (lap == LapW'(TableSlots));
  assign sts.have_free = have_free;

  // Slot memories, read registered.
  assign wr_addr = cmd.wr_ins ? free_slot : hit_slot;
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key <= mem_key[pos];
      rd_len <= mem_len[pos];
      rd_st  <= status[pos];
      rd_pos <= pos;
    end
    if (cmd.wr_ins) begin
      mem_key[wr_addr] <= key;
      mem_len[wr_addr] <= len;
    end
    if (cmd.wr_ins || cmd.wr_val) begin
      mem_val[wr_addr] <= value;
    end
    if (cmd.eval) begin
      hit_value <= mem_val[rd_pos];
    end
  end

  assign sts.clear_done = (clr_ptr == SlotW'(TableSlots - 1));

  // Status memory and live count. A wipe marks one slot unused per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      live    <= '0;
    end else if (cmd.clear_step) begin
      status[clr_ptr] <= StUnused;
      clr_ptr <= clr_ptr + 1'b1;
      live <= '0;
    end else if (cmd.wr_ins) begin
      status[wr_addr] <= StInUse;
      live <= live + 1'b1;
    end else if (cmd.del) begin
      status[wr_addr] <= StDeleted;
      if (live != '0) live <= live - 1'b1;
    end
  end

endmodule

FILE: rtl/htlp_ctrl.sv
// Controller of the hash table: sequences hashing, the probe walk, the
// slot wipe and the final slot update, and holds the result word. Uses htlp_pkg.
`timescale 1ns / 1ps

module htlp_ctrl
  import htlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  htlp_sts_t  sts,
  output htlp_cmd_t  cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] rc
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SHash  = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SEval  = 3'd3;
  localparam logic [2:0] SDone  = 3'd4;
  localparam logic [2:0] SInit  = 3'd5;
  localparam logic [2:0] SWipe  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] rc_next;
  logic       fin;

  assign in_ready = (state == SIdle) && !out_valid;

  // Next-state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    rc_next    = rc;
    fin        = 1'b0;
    unique case (state)
      SIdle: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = SHash;
        end
      end
      SHash: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          if (action == ActClear) begin
            rc_next = RcOk;
            state_next = SWipe;
          end else if (action > ActClear) begin
            rc_next = RcOk;
            fin = 1'b1;
          end else if (action == ActInsert && sts.full) begin
            rc_next = RcFull;
            fin = 1'b1;
          end else begin
            cmd.probe_init = 1'b1;
            state_next = SRead;
          end
        end
      end
      SRead: begin
        cmd.rd = 1'b1;
        state_next = SEval;
      end
      SEval: begin
        cmd.eval = 1'b1;
        if (sts.hit) begin
          state_next = SDone;
          rc_next = (action == ActInsert) ? RcDup : RcOk;
        end else if (sts.stop) begin
          state_next = SDone;
          rc_next = RcNotFound;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      SDone: begin
        fin = 1'b1;
        if (action == ActInsert && rc != RcDup) begin
          if (sts.have_free) begin
            cmd.wr_ins = 1'b1;
            rc_next = RcOk;
          end else begin
            rc_next = RcFull;
          end
        end else if (rc == RcOk && action == ActUpdate) begin
          cmd.wr_val = 1'b1;
        end else if (rc == RcOk && action == ActRemove) begin
          cmd.del = 1'b1;
        end
      end
      // Wipe after reset: no result word is produced.
      SInit: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = SIdle;
      end
      // Wipe for a clear request, answered when the last slot is done.
      SWipe: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) fin = 1'b1;
      end
      default: state_next = SIdle;
    endcase
    if (fin) state_next = SIdle;
  end

  // State, result code and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SInit;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    rc <= rc_next;
  end

endmodule

FILE: rtl/hash_table_linear_probe.sv
// Top level of the linear-probe hash table: stream ports, fill limit
// register, controller and datapath. Uses htlp_pkg, htlp_ctrl, htlp_datapath.
//
//   Channel | Direction | Word
//   s_axis  | in        | tdata: action[2:0] key_bytes[66:3] key_length[70:67] value_in[134:71]
//   m_axis  | out       | tdata: result_code[1:0] value_out[65:2]
//   cfg     | in        | fill_limit, written when cfg_we is high
//
// One request at a time: hashing over the key characters, then a read and an
// evaluation of each probed slot, then the final slot update in the done state.
// A clear runs a wipe of all 64 slots, one slot per cycle, in place of the probe.
// The probe walk over the slot memory sets the rate. Reset is synchronous
// and is followed by the same wipe of all slots before the first request is
// taken. A result waiting in the output register holds off the next request.
`timescale 1ns / 1ps

module hash_table_linear_probe
  import htlp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, key_bytes, key_length, value_in; zero padded to 136 bits
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_code, value_out; zero padded to 72 bits
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  htlp_cmd_t        cmd;
  htlp_sts_t        sts;
  logic [2:0]       action;
  logic [ValW-1:0]  hit_value;
  logic [1:0]       rc;
  logic [CountW-1:0] fill_limit;
  logic [ValW-1:0]  vout;

  // Fill limit register.
  always_ff @(posedge clk) begin
    if (rst) fill_limit <= CountW'(63);
    else if (cfg_we) fill_limit <= cfg_wdata;
  end

  htlp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .action    (action),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .rc        (rc)
  );

  htlp_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .action_in  (s_axis_tdata[2:0]),
    .key_in     (s_axis_tdata[66:3]),
    .len_in     (s_axis_tdata[70:67]),
    .val_in     (s_axis_tdata[134:71]),
    .fill_limit (fill_limit),
    .action     (action),
    .hit_value  (hit_value)
  );

  // Value is returned only for a successful search.
  assign vout = (action == ActSearch && rc == RcOk) ? hit_value : '0;
  assign m_axis_tdata = {6'd0, vout, rc};

endmodule

FILE: dv/tb.sv
// Testbench for the linear-probe hash table: drives request words, predicts
// each result with its own table model and checks every result word.
// Depends on htlp_pkg and hash_table_linear_probe.
`timescale 1ns / 1ps

class table_scoreboard;
  logic [1:0]  status_q[64];
  logic [63:0] key_q[64];
  logic [3:0]  len_q[64];
  logic [63:0] val_q[64];
  int unsigned live;
  int unsigned limit;
  logic [65:0] pending[$];
  int errors;
  int results_seen;

  function new();
    reset_table();
    limit = 63;
  endfunction

  function void reset_table();
    for (int i = 0; i < 64; i++) status_q[i] = htlp_pkg::StUnused;
    live = 0;
  endfunction

  function automatic int home_of(logic [63:0] k, int unsigned n);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < n; i++) h = h * i + k[8*i +: 8];
    return h % 64;
  endfunction

  // Returns the hit slot or -1; free_pos gets the first deleted or ending unused slot.
  function automatic int walk(logic [63:0] k, int unsigned n, output int free_pos);
    int pos;
    int first_del;
    pos = home_of(k, n);
    first_del = -1;
    free_pos = -1;
    for (int c = 0; c < 64; c++) begin
      if (status_q[pos] == htlp_pkg::StUnused) begin
        free_pos = (first_del >= 0) ? first_del : pos;
        return -1;
      end
      if (status_q[pos] == htlp_pkg::StDeleted && first_del < 0) first_del = pos;
      if (status_q[pos] == htlp_pkg::StInUse && len_q[pos] == n && key_q[pos] == k)
        return pos;
      pos = (pos + 1) % 64;
    end
    free_pos = first_del;
    return -1;
  endfunction

  // Notes an accepted request and queues its expected result.
  function void note_request(logic [2:0] act, logic [63:0] kb, logic [3:0] kl,
                             logic [63:0] v);
    int unsigned n;
    logic [63:0] k;
    logic [1:0] rc;
    logic [63:0] vo;
    int hit;
    int fr;
    n = (kl > 8) ? 8 : kl;
    k = (n >= 8) ? kb : (kb & ((64'd1 << (8 * n)) - 64'd1));
    rc = htlp_pkg::RcOk;
    vo = '0;
    case (act)
      htlp_pkg::ActSearch: begin
        hit = walk(k, n, fr);
        if (hit >= 0) vo = val_q[hit];
        else rc = htlp_pkg::RcNotFound;
      end
      htlp_pkg::ActUpdate: begin
        hit = walk(k, n, fr);
        if (hit >= 0) val_q[hit] = v;
        else rc = htlp_pkg::RcNotFound;
      end
      htlp_pkg::ActInsert: begin
        if (live >= limit) rc = htlp_pkg::RcFull;
        else begin
          hit = walk(k, n, fr);
          if (hit >= 0) rc = htlp_pkg::RcDup;
          else if (fr < 0) rc = htlp_pkg::RcFull;
          else begin
            key_q[fr] = k;
            len_q[fr] = 4'(n);
            val_q[fr] = v;
            status_q[fr] = htlp_pkg::StInUse;
            live++;
          end
        end
      end
      htlp_pkg::ActRemove: begin
        hit = walk(k, n, fr);
        if (hit >= 0) begin
          status_q[hit] = htlp_pkg::StDeleted;
          if (live > 0) live--;
        end else rc = htlp_pkg::RcNotFound;
      end
      htlp_pkg::ActClear: reset_table();
      default: ;
    endcase
    pending.push_back({vo, rc});
  endfunction

  // Checks one result word against the oldest expectation.
  task check_result(logic [71:0] word);
    logic [65:0] exp_w;
    results_seen++;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %h", word));
      return;
    end
    exp_w = pending.pop_front();
    if (word[1:0] !== exp_w[1:0])
      report_mismatch($sformatf("result_code got %0d want %0d", word[1:0], exp_w[1:0]));
    if (word[65:2] !== exp_w[65:2])
      report_mismatch($sformatf("value_out got %h want %h", word[65:2], exp_w[65:2]));
    if (word[71:66] !== 6'd0)
      report_mismatch($sformatf("padding bits not zero: %h", word[71:66]));
  endtask

  task report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask
endclass

module tb;
  import htlp_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic         cfg_we;
  logic [6:0]   cfg_wdata;

  table_scoreboard sb;
  bit quiet_tail;
  bit hold_sink;
  int words_sent;
  // Keys reused so that hits, duplicates and removes happen often.
  logic [63:0] key_pool[16];
  logic [3:0]  len_pool[16];

  hash_table_linear_probe dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Timeout waiting for results");
    $display("RESULT: ERROR");
    $finish;
  end

  // Sink side: random stall bursts, optional long hold-off, result checking.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_sink = 0;
      end
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Sends one request word and waits for its acceptance.
  task automatic send_request(logic [2:0] act, logic [63:0] kb, logic [3:0] kl,
                              logic [63:0] v);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, v, kl, kb, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(act, kb, kl, v);
    words_sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = lim;
  endtask

  task automatic random_request();
    int p;
    logic [2:0] act;
    logic [63:0] kb;
    logic [3:0] kl;
    p = $urandom_range(0, 15);
    act = $urandom_range(0, 99) < 2 ? ActClear : 3'($urandom_range(0, 3));
    if ($urandom_range(0, 49) == 0) act = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 4) == 0) begin
      kb = {$urandom, $urandom};
      kl = 4'($urandom_range(0, 15));
    end else begin
      // Same valid bytes, random junk above the length.
      kl = len_pool[p];
      kb = key_pool[p];
      if (kl < 8) kb = kb | ({$urandom, $urandom} << (8 * kl));
      if (kl == 8 && $urandom_range(0, 1)) kl = 4'($urandom_range(9, 15));
    end
    send_request(act, kb, kl, {$urandom, $urandom});
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    quiet_tail = 0;
    hold_sink = 0;
    words_sent = 0;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = 4'($urandom_range(0, 8));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, every action, aliasing of long keys.
    send_request(ActSearch, '1, 4'd8, '0);
    send_request(ActInsert, '1, 4'd8, '1);
    send_request(ActInsert, '1, 4'd15, '0);
    send_request(ActSearch, '1, 4'd12, '0);
    send_request(ActInsert, 64'h0, 4'd0, 64'h1234);
    send_request(ActSearch, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, '0);
    send_request(ActInsert, 64'hAB, 4'd1, 64'h55);
    send_request(ActSearch, 64'hFFAB, 4'd1, '0);
    send_request(ActUpdate, 64'hAB, 4'd1, 64'hDEAD_BEEF);
    send_request(ActSearch, 64'hAB, 4'd1, '0);
    send_request(ActUpdate, 64'hAC, 4'd1, 64'h1);
    send_request(ActRemove, 64'hAB, 4'd1, '0);
    send_request(ActRemove, 64'hAB, 4'd1, '0);
    send_request(ActInsert, 64'hCD, 4'd1, 64'h77);
    send_request(3'd5, '1, 4'd8, '1);
    send_request(3'd7, '0, 4'd0, '0);
    send_request(ActClear, '0, 4'd0, '0);
    send_request(ActSearch, '1, 4'd8, '0);
    go_idle();

    // Smallest limits: at 1 the second insert reports full, at 0 the next insert does too.
    write_limit(7'd1);
    send_request(ActInsert, 64'h11, 4'd2, 64'h1);
    send_request(ActInsert, 64'h22, 4'd2, 64'h2);
    go_idle();
    write_limit(7'd0);
    send_request(ActInsert, 64'h33, 4'd2, 64'h3);
    go_idle();

    // Limit of 64: fill every slot so full laps and full reports occur.
    write_limit(7'd64);
    send_request(ActClear, '0, 4'd0, '0);
    for (int i = 0; i < 70; i++)
      send_request(ActInsert, {$urandom, $urandom}, 4'd8, {$urandom, $urandom});
    for (int i = 0; i < 4; i++) send_request(ActSearch, {$urandom, $urandom}, 4'd8, '0);
    send_request(ActUpdate, 64'h99, 4'd3, '0);
    send_request(ActClear, '0, 4'd0, '0);
    go_idle();

    // Random phases across several limits, with one long sink hold-off.
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(ph == 0 ? 7'd63 : ph == 1 ? 7'd8 : ph == 2 ? 7'd64 : 7'd20);
      if (ph == 1) hold_sink = 1;
      if (ph == 3) quiet_tail = 1;
      for (int i = 0; i < 200; i++) random_request();
      go_idle();
    end
    write_limit(7'd127);
    for (int i = 0; i < 40; i++) random_request();
    go_idle();

    $display("Sent %0d requests over limits 0 to 127, checked %0d results.",
             words_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/htlp_pkg.sv
rtl/htlp_datapath.sv
rtl/htlp_ctrl.sv
rtl/hash_table_linear_probe.sv
dv/tb.sv
